// ===== rtl/flsq_pkg.sv =====
// Shared types, command codes and constants for the flash ring log sequencer.
package flsq_pkg;

  // Flash geometry and run limits.
  localparam int SECTOR_BYTES = 4096;
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam logic [12:0] SECTOR_LEN = 13'(SECTOR_BYTES % 8192);
  localparam int MAX_RUN = 64;

  // Configuration register indexes (word addresses on the APB port).
  localparam logic [1:0] REG_BASE     = 2'd0;
  localparam logic [1:0] REG_RBYTES   = 2'd1;
  localparam logic [1:0] REG_CAPACITY = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [23:0] BASE_RESET     = 24'd0;
  localparam logic [12:0] RBYTES_RESET   = 13'd16;
  localparam logic [15:0] CAPACITY_RESET = 16'd256;

  // Result command codes.
  typedef enum logic [1:0] {
    CMD_ERASE = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_EMPTY = 2'd3
  } cmd_t;

  // Dividend selection for the remainder unit.
  typedef enum logic [1:0] {
    MSEL_WS_INC,
    MSEL_WS,
    MSEL_STORED,
    MSEL_OLD_START
  } msel_t;

  // Multiplier operand selection.
  typedef enum logic [1:0] {
    MUL_WS,
    MUL_PREV,
    MUL_SLOT
  } mulsel_t;

  // Kind of word loaded into the output register.
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_ERASE,
    EMIT_WRITE,
    EMIT_READ,
    EMIT_EMPTY
  } emit_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch;
    logic    mod_start;
    msel_t   mod_sel;
    logic    mul_en;
    mulsel_t mul_sel;
    logic    addr_en;
    logic    paddr_en;
    logic    wsm_en;
    logic    oldest_en;
    logic    slot_en;
    logic    commit;
    emit_t   emit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;
    logic cnt_zero;
    logic mod_busy;
    logic erase_need;
    logic out_free;
    logic run_last;
  } ctl_stat_t;

endpackage

// ===== rtl/flash_ring_log_sequencer.sv =====
// An append gives its erase and write words and takes the next request only once the remainder
// for the slot wrap is done. A read of N records gives its first word after three bit-serial
// remainder runs, then one word per cycle while the output is not stalled, and takes the next
// request once its last word is given; an empty read gives its word with no remainder run.
// Synchronous reset clears slot, count, registers and valid.
// Top level: APB register file, controller and datapath.
module flash_ring_log_sequencer import flsq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [15:0] start_position,
  input  logic [6:0]  request_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  command,
  output logic [31:0] flash_address,
  output logic [12:0] length_bytes,
  output logic [5:0]  run_position,
  output logic [6:0]  run_count,
  output logic        last
);

  logic [23:0] base_address;
  logic [12:0] record_bytes;
  logic [15:0] record_capacity;
  logic        cfg_write;
  ctl_cmd_t    cmd;
  ctl_stat_t   stat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address    <= BASE_RESET;
      record_bytes    <= RBYTES_RESET;
      record_capacity <= CAPACITY_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_BASE:     base_address    <= pwdata[23:0];
        REG_RBYTES:   record_bytes    <= pwdata[12:0];
        REG_CAPACITY: record_capacity <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_BASE:     prdata = {8'd0, base_address};
      REG_RBYTES:   prdata = {19'd0, record_bytes};
      REG_CAPACITY: prdata = {16'd0, record_capacity};
      default:      prdata = '0;
    endcase
  end

  flsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  flsq_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .base_address    (base_address),
    .record_bytes    (record_bytes),
    .record_capacity (record_capacity),
    .mode            (mode),
    .start_position  (start_position),
    .request_length  (request_length),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .command         (command),
    .flash_address   (flash_address),
    .length_bytes    (length_bytes),
    .run_position    (run_position),
    .run_count       (run_count),
    .last            (last)
  );

endmodule

// ===== rtl/flsq_mod.sv =====
// Bit-serial remainder unit: dividend modulo divisor, one quotient bit per cycle.
module flsq_mod import flsq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [15:0] rem
);

  logic [16:0] dvd;
  logic [4:0]  count;
  logic [16:0] trial;

  // Shift the next dividend bit into the partial remainder.
  assign trial = {rem, dvd[16]};

  // Restoring step per cycle; the result holds until the next start.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 5'd17;
      dvd   <= dividend;
      rem   <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= 16'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[15:0];
      end
      dvd   <= {dvd[15:0], 1'b0};
      count <= count - 5'd1;
      if (count == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/flsq_dpath.sv =====
// Datapath: log state, address arithmetic, remainder unit and output register.
module flsq_dpath import flsq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [23:0] base_address,
  input  logic [12:0] record_bytes,
  input  logic [15:0] record_capacity,
  input  logic        mode,
  input  logic [15:0] start_position,
  input  logic [6:0]  request_length,
  input  ctl_cmd_t    cmd,
  output ctl_stat_t   stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  command,
  output logic [31:0] flash_address,
  output logic [12:0] length_bytes,
  output logic [5:0]  run_position,
  output logic [6:0]  run_count,
  output logic        last
);

  logic [15:0] ws;
  logic [15:0] stored;
  logic        mode_r;
  logic [15:0] start_r;
  logic [6:0]  cnt_r;
  logic [28:0] prod;
  logic [31:0] addr;
  logic [31:0] paddr;
  logic [15:0] wsm;
  logic [15:0] oldest;
  logic [15:0] slot;
  logic [5:0]  pos;

  logic [15:0] cap;
  logic [6:0]  len_sat;
  logic [15:0] diff;
  logic [6:0]  cnt_next;
  logic [16:0] mod_dvd;
  logic        mod_busy;
  logic [15:0] mod_rem;
  logic [15:0] mul_a;
  logic [28:0] prod_next;
  logic [31:0] addr_sum;
  logic [16:0] om;
  logic [15:0] oldest_next;
  logic        run_last;
  logic        out_free;

  // A capacity of zero acts as one slot.
  assign cap = (record_capacity == 16'd0) ? 16'd1 : record_capacity;

  // Records actually returned by a read request.
  assign len_sat = (request_length > 7'(MAX_RUN)) ? 7'(MAX_RUN) : request_length;
  assign diff    = stored - start_position;
  always_comb begin
    cnt_next = '0;
    if (stored != 16'd0 && start_position < stored) begin
      cnt_next = (diff < {9'd0, len_sat}) ? diff[6:0] : len_sat;
    end
  end

  // Dividend selection for the shared remainder unit.
  always_comb begin
    case (cmd.mod_sel)
      MSEL_WS_INC:    mod_dvd = {1'b0, ws} + 17'd1;
      MSEL_WS:        mod_dvd = {1'b0, ws};
      MSEL_STORED:    mod_dvd = {1'b0, stored};
      MSEL_OLD_START: mod_dvd = {1'b0, oldest} + {1'b0, start_r};
      default:        mod_dvd = '0;
    endcase
  end

  flsq_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (mod_dvd),
    .divisor  (cap),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  // Slot times record size, then plus base; the sum cannot overflow 32 bits.
  always_comb begin
    case (cmd.mul_sel)
      MUL_WS:   mul_a = ws;
      MUL_PREV: mul_a = (ws == 16'd0) ? cap - 16'd1 : ws - 16'd1;
      MUL_SLOT: mul_a = slot;
      default:  mul_a = '0;
    endcase
  end
  assign prod_next = 29'(mul_a) * 29'(record_bytes);
  assign addr_sum  = {8'd0, base_address} + {3'd0, prod};

  // Oldest slot from the reduced write slot and the reduced count.
  assign om          = {1'b0, wsm} + {1'b0, cap} - {1'b0, mod_rem};
  assign oldest_next = (om >= {1'b0, cap}) ? 16'(om - {1'b0, cap}) : om[15:0];

  assign run_last = ({1'b0, pos} + 7'd1 == cnt_r);
  assign out_free = !out_valid || out_ready;

  // Status back to the controller.
  assign stat.mode       = mode_r;
  assign stat.cnt_zero   = (cnt_r == 7'd0);
  assign stat.mod_busy   = mod_busy;
  assign stat.erase_need = (addr[31:SECTOR_SHIFT] != paddr[31:SECTOR_SHIFT]) || (ws == 16'd0);
  assign stat.out_free   = out_free;
  assign stat.run_last   = run_last;

  // Log state: write slot and saturating record count.
  always_ff @(posedge clk) begin
    if (rst) begin
      ws     <= '0;
      stored <= '0;
    end else if (cmd.commit) begin
      ws <= mod_rem;
      if (stored < cap) begin
        stored <= stored + 16'd1;
      end
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r  <= mode;
      start_r <= start_position;
      cnt_r   <= cnt_next;
      pos     <= '0;
    end
    if (cmd.mul_en) begin
      prod <= prod_next;
    end
    if (cmd.paddr_en) begin
      paddr <= addr_sum;
    end
    if (cmd.wsm_en) begin
      wsm <= mod_rem;
    end
    if (cmd.oldest_en) begin
      oldest <= oldest_next;
    end
    // Walk the run one slot at a time, wrapping back to the region start.
    if (cmd.emit == EMIT_READ) begin
      pos <= pos + 6'd1;
      if ({1'b0, slot} + 17'd1 == {1'b0, cap}) begin
        slot <= '0;
        addr <= {8'd0, base_address};
      end else begin
        slot <= slot + 16'd1;
        addr <= addr + {19'd0, record_bytes};
      end
    end else begin
      if (cmd.slot_en) begin
        slot <= mod_rem;
      end
      if (cmd.addr_en) begin
        addr <= addr_sum;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output word payload.
  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_ERASE: begin
        command       <= CMD_ERASE;
        flash_address <= {addr[31:SECTOR_SHIFT], {SECTOR_SHIFT{1'b0}}};
        length_bytes  <= SECTOR_LEN;
        run_position  <= '0;
        run_count     <= '0;
        last          <= 1'b0;
      end
      EMIT_WRITE: begin
        command       <= CMD_WRITE;
        flash_address <= addr;
        length_bytes  <= record_bytes;
        run_position  <= '0;
        run_count     <= '0;
        last          <= 1'b1;
      end
      EMIT_READ: begin
        command       <= CMD_READ;
        flash_address <= addr;
        length_bytes  <= record_bytes;
        run_position  <= pos;
        run_count     <= cnt_r;
        last          <= run_last;
      end
      EMIT_EMPTY: begin
        command       <= CMD_EMPTY;
        flash_address <= '0;
        length_bytes  <= '0;
        run_position  <= '0;
        run_count     <= '0;
        last          <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/flsq_ctrl.sv =====
// Controller: sequences append and read requests through the datapath.
module flsq_ctrl import flsq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_A_PREV,
    S_A_PADDR,
    S_A_ERASE,
    S_A_WRITE,
    S_A_WAIT,
    S_R_WAIT_WS,
    S_R_WAIT_ST,
    S_R_OLD,
    S_R_WAIT_SL,
    S_R_MUL,
    S_R_ADDR,
    S_R_EMIT,
    S_R_EMPTY
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!stat.mode) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_WS;
          state_next  = S_A_PREV;
        end else if (stat.cnt_zero) begin
          state_next = S_R_EMPTY;
        end else begin
          cmd.mod_start = 1'b1;
          cmd.mod_sel   = MSEL_WS;
          state_next    = S_R_WAIT_WS;
        end
      end
      S_A_PREV: begin
        cmd.addr_en = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PREV;
        state_next  = S_A_PADDR;
      end
      S_A_PADDR: begin
        cmd.paddr_en  = 1'b1;
        cmd.mod_start = 1'b1;
        cmd.mod_sel   = MSEL_WS_INC;
        state_next    = S_A_ERASE;
      end
      S_A_ERASE: begin
        if (!stat.erase_need) begin
          state_next = S_A_WRITE;
        end else if (stat.out_free) begin
          cmd.emit   = EMIT_ERASE;
          state_next = S_A_WRITE;
        end
      end
      S_A_WRITE: begin
        if (stat.out_free) begin
          cmd.emit   = EMIT_WRITE;
          state_next = S_A_WAIT;
        end
      end
      S_A_WAIT: begin
        if (!stat.mod_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_R_WAIT_WS: begin
        if (!stat.mod_busy) begin
          cmd.wsm_en    = 1'b1;
          cmd.mod_start = 1'b1;
          cmd.mod_sel   = MSEL_STORED;
          state_next    = S_R_WAIT_ST;
        end
      end
      S_R_WAIT_ST: begin
        if (!stat.mod_busy) begin
          cmd.oldest_en = 1'b1;
          state_next    = S_R_OLD;
        end
      end
      S_R_OLD: begin
        cmd.mod_start = 1'b1;
        cmd.mod_sel   = MSEL_OLD_START;
        state_next    = S_R_WAIT_SL;
      end
      S_R_WAIT_SL: begin
        if (!stat.mod_busy) begin
          cmd.slot_en = 1'b1;
          state_next  = S_R_MUL;
        end
      end
      S_R_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SLOT;
        state_next  = S_R_ADDR;
      end
      S_R_ADDR: begin
        cmd.addr_en = 1'b1;
        state_next  = S_R_EMIT;
      end
      S_R_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = EMIT_READ;
          if (stat.run_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_R_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit   = EMIT_EMPTY;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/flsq_checker.sv =====
// Port-level assertions for the sequencer and the bind that attaches them.
module flsq_checker import flsq_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  command,
  input logic [31:0] flash_address,
  input logic [12:0] length_bytes,
  input logic [5:0]  run_position,
  input logic [6:0]  run_count,
  input logic        last
);

  // A stalled output word holds its command, address, run position and last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(command) && $stable(flash_address)
      && $stable(last) && $stable(run_position))
    else $error("output word changed while stalled");

  // One request at a time: input closes right after an accepted word.
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // An empty read is a single final word with zero address and length.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && command == CMD_EMPTY |->
      last && flash_address == 32'd0 && length_bytes == 13'd0 && run_count == 7'd0)
    else $error("malformed empty read word");

  // Read words count up to the run length and close on its final word.
  a_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && command == CMD_READ |->
      ({1'b0, run_position} < run_count) && (last == ({1'b0, run_position} + 7'd1 == run_count)))
    else $error("read run position or last flag wrong");

  // An erase is always followed by a write, so it never ends an item.
  a_erase: assert property (@(posedge clk) disable iff (rst)
    out_valid && command == CMD_ERASE |-> !last)
    else $error("erase word marked last");

endmodule

bind flash_ring_log_sequencer flsq_checker u_flsq_checker (.*);

// ===== tb/sv/flsq_log_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts the command words of the flash ring log sequencer and compares them.
module flsq_log_checker import flsq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        mode,
  input  logic [15:0] start_position,
  input  logic [6:0]  request_length,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  command,
  input  logic [31:0] flash_address,
  input  logic [12:0] length_bytes,
  input  logic [5:0]  run_position,
  input  logic [6:0]  run_count,
  input  logic        last,
  output int          words_pending,
  output int          mismatch_total
);

  // One command word as it leaves the block.
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] addr;
    logic [12:0] len;
    logic [5:0]  pos;
    logic [6:0]  cnt;
    logic        lst;
  } log_word_t;

  // Shadow copy of the registers and of the ring state.
  logic [23:0] base_q;
  logic [12:0] rbytes_q;
  logic [15:0] cap_q;
  logic [15:0] wslot_q;
  logic [15:0] stored_q;

  log_word_t   expected_words[$];
  int          mismatches;
  log_word_t   got;
  log_word_t   want;
  logic [31:0] reg_want;
  bit          reg_known;

  function automatic log_word_t make_word(cmd_t c, logic [31:0] a, logic [12:0] n,
                                          logic [5:0] p, logic [6:0] k, logic l);
    log_word_t w;
    w.cmd  = c;
    w.addr = a;
    w.len  = n;
    w.pos  = p;
    w.cnt  = k;
    w.lst  = l;
    return w;
  endfunction

  // Byte address of a record slot in flash.
  function automatic logic [31:0] record_addr(logic [31:0] slot);
    return 32'(base_q) + slot * 32'(rbytes_q);
  endfunction

  // Work out the words that one accepted request causes and update the ring state.
  task automatic queue_log_commands(input logic m, input logic [15:0] sp, input logic [6:0] rl);
    logic [31:0] cap;
    logic [31:0] slot;
    logic [31:0] prev;
    logic [31:0] addr;
    logic [31:0] total;
    logic [31:0] run_len;
    logic [31:0] run_cnt;
    logic [31:0] oldest;
    logic [31:0] k;
    cap = (cap_q == 16'd0) ? 32'd1 : 32'(cap_q);
    if (m == 1'b0) begin
      // Append: erase the sector first when the slot starts a new sector or the ring.
      slot = 32'(wslot_q);
      addr = record_addr(slot);
      prev = (slot == 32'd0) ? cap - 32'd1 : slot - 32'd1;
      if (slot == 32'd0 ||
          addr / 32'(SECTOR_BYTES) != record_addr(prev) / 32'(SECTOR_BYTES)) begin
        expected_words.push_back(make_word(CMD_ERASE,
            (addr / 32'(SECTOR_BYTES)) * 32'(SECTOR_BYTES), SECTOR_LEN, '0, '0, 1'b0));
      end
      expected_words.push_back(make_word(CMD_WRITE, addr, rbytes_q, '0, '0, 1'b1));
      wslot_q = 16'((slot + 32'd1) % cap);
      if (32'(stored_q) < cap) stored_q = stored_q + 16'd1;
    end else begin
      // Read: clamp the run to what is stored past the start position.
      total   = 32'(stored_q);
      run_len = (32'(rl) > 32'(MAX_RUN)) ? 32'(MAX_RUN) : 32'(rl);
      run_cnt = 32'd0;
      if (total != 32'd0 && 32'(sp) < total) begin
        run_cnt = total - 32'(sp);
        if (run_cnt > run_len) run_cnt = run_len;
      end
      if (run_cnt == 32'd0) begin
        expected_words.push_back(make_word(CMD_EMPTY, '0, '0, '0, '0, 1'b1));
      end else begin
        oldest = ((32'(wslot_q) % cap) + cap - (total % cap)) % cap;
        for (k = 32'd0; k < run_cnt; k++) begin
          slot = (oldest + 32'(sp) + k) % cap;
          expected_words.push_back(make_word(CMD_READ, record_addr(slot), rbytes_q,
              k[5:0], run_cnt[6:0], (k + 32'd1 == run_cnt)));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      base_q   = BASE_RESET;
      rbytes_q = RBYTES_RESET;
      cap_q    = CAPACITY_RESET;
      wslot_q  = '0;
      stored_q = '0;
      expected_words.delete();
    end else begin
      // Register writes update the shadow copy; register reads are checked against it.
      if (psel && penable && pready) begin
        reg_known = 1'b1;
        reg_want  = '0;
        case (paddr[3:2])
          REG_BASE: begin
            if (pwrite) base_q = pwdata[23:0];
            reg_want = 32'(base_q);
          end
          REG_RBYTES: begin
            if (pwrite) rbytes_q = pwdata[12:0];
            reg_want = 32'(rbytes_q);
          end
          REG_CAPACITY: begin
            if (pwrite) cap_q = pwdata[15:0];
            reg_want = 32'(cap_q);
          end
          default: reg_known = 1'b0;
        endcase
        if (!pwrite && reg_known && prdata !== reg_want) begin
          mismatches++;
          $display("%0t: register read at %h: expected %h, got %h",
                   $time, paddr, reg_want, prdata);
        end
      end

      // Each word taken from the block is compared with the oldest expectation.
      if (out_valid && out_ready) begin
        got = make_word(cmd_t'(command), flash_address, length_bytes, run_position,
                        run_count, last);
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word: expected none", $time);
          $display("%0t:   got cmd %0d addr %h len %0d pos %0d cnt %0d last %0d",
                   $time, got.cmd, got.addr, got.len, got.pos, got.cnt, got.lst);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: mismatch: expected cmd %0d addr %h len %0d pos %0d cnt %0d last %0d",
                     $time, want.cmd, want.addr, want.len, want.pos, want.cnt, want.lst);
            $display("%0t:                got cmd %0d addr %h len %0d pos %0d cnt %0d last %0d",
                     $time, got.cmd, got.addr, got.len, got.pos, got.cnt, got.lst);
          end
        end
      end

      if (in_valid && in_ready) queue_log_commands(mode, start_position, request_length);
    end
    words_pending  <= expected_words.size();
    mismatch_total <= mismatches;
  end

endmodule

// ===== tb/sv/flash_ring_log_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the flash ring log sequencer: clock, reset, stimulus and verdict.
module flash_ring_log_sequencer_tb;
  import flsq_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic        mode;
  logic [15:0] start_position;
  logic [6:0]  request_length;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  command;
  logic [31:0] flash_address;
  logic [12:0] length_bytes;
  logic [5:0]  run_position;
  logic [6:0]  run_count;
  logic        last;
  int          words_pending;
  int          mismatch_total;

  // Rough fill level and capacity, only used to aim read positions at stored records.
  int fill_est;
  int cap_now;
  bit gaps_on;

  flash_ring_log_sequencer dut (.*);

  flsq_log_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is cut off if it hangs.
  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Pause lengths: mostly none or short, now and then long.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (wr && idx == REG_CAPACITY) cap_now = (value[15:0] == 16'd0) ? 1 : int'(value[15:0]);
  endtask

  // Offer one request word and hold it until the block takes it.
  task automatic send_request(input logic m, input logic [15:0] sp, input logic [6:0] rl);
    int gap;
    gap = gaps_on ? pick_pause() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    mode           <= m;
    start_position <= sp;
    request_length <= rl;
    do @(posedge clk); while (!in_ready);
    if (m == 1'b0 && fill_est < cap_now) fill_est++;
  endtask

  task automatic append_record();
    send_request(1'b0, 16'($urandom), 7'($urandom));
  endtask

  // Random request: half appends, reads mostly within the stored records.
  task automatic send_random();
    logic [15:0] sp;
    logic [6:0]  rl;
    int          r;
    if ($urandom_range(0, 1) == 0) begin
      append_record();
    end else begin
      r  = $urandom_range(0, 99);
      sp = (r < 12) ? 16'($urandom) : 16'($urandom_range(0, fill_est + 1));
      r  = $urandom_range(0, 99);
      if (r < 8) rl = 7'd0;
      else if (r < 18) rl = 7'($urandom_range(65, 127));
      else if (r < 50) rl = 7'($urandom_range(1, 8));
      else rl = 7'($urandom_range(1, 64));
      send_request(1'b1, sp, rl);
    end
  endtask

  // Let the block drain: every expected word out, then time for its internal update.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Sink side: bursts of ready with stalls, sometimes a long stretch without stalls.
  initial begin
    int stall;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(100, 300)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
        stall = pick_pause();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int          phase;
    logic [23:0] base_val;
    logic [12:0] rb_val;
    logic [15:0] cap_val;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    mode           = 1'b0;
    start_position = '0;
    request_length = '0;
    fill_est       = 0;
    cap_now        = 256;
    gaps_on        = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty log, zero and long lengths, a start past the end.
    send_request(1'b1, 16'd0, 7'd5);
    repeat (3) append_record();
    send_request(1'b1, 16'd0, 7'd0);
    send_request(1'b1, 16'd0, 7'd127);
    send_request(1'b1, 16'hFFFF, 7'd64);
    send_request(1'b1, 16'd1, 7'd1);
    settle();

    // Capacity lowered below the write slot and the stored count.
    apb_access(1'b1, REG_CAPACITY, 32'd2);
    apb_access(1'b0, REG_CAPACITY, 32'd0);
    append_record();
    send_request(1'b1, 16'd0, 7'd64);
    append_record();
    send_request(1'b1, 16'd0, 7'd64);
    settle();

    // Zero capacity acts as one slot; sector-sized records at the top of the region.
    apb_access(1'b1, REG_CAPACITY, 32'd0);
    apb_access(1'b1, REG_RBYTES, 32'd4096);
    apb_access(1'b1, REG_BASE, 32'h00FF_FFFF);
    repeat (2) append_record();
    send_request(1'b1, 16'd0, 7'd3);
    settle();

    // Zero-size records over the largest ring.
    apb_access(1'b1, REG_RBYTES, 32'd0);
    apb_access(1'b1, REG_CAPACITY, 32'd65535);
    append_record();
    send_request(1'b1, 16'd0, 7'd10);
    settle();

    // Record size beyond the legal range, upper write bits set.
    apb_access(1'b1, REG_RBYTES, 32'hFFFF_FFFF);
    apb_access(1'b0, REG_RBYTES, 32'd0);
    repeat (2) append_record();
    send_request(1'b1, 16'd0, 7'd127);
    settle();

    // Random phases, each under its own register setting.
    for (phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 3))
        0:       base_val = 24'd0;
        1:       base_val = 24'hFF_FFFF;
        default: base_val = 24'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0:       rb_val = 13'd1;
        1:       rb_val = 13'd4096;
        2:       rb_val = 13'd0;
        3:       rb_val = 13'd8191;
        4:       rb_val = 13'($urandom_range(1024, 4096));
        default: rb_val = 13'($urandom_range(1, 4096));
      endcase
      case ($urandom_range(0, 5))
        0:       cap_val = 16'd1;
        1:       cap_val = 16'd0;
        2:       cap_val = 16'd65535;
        3:       cap_val = 16'($urandom_range(2, 8));
        4:       cap_val = 16'($urandom_range(9, 300));
        default: cap_val = 16'($urandom);
      endcase
      apb_access(1'b1, REG_BASE, {8'($urandom), base_val});
      apb_access(1'b1, REG_RBYTES, {19'($urandom), rb_val});
      apb_access(1'b1, REG_CAPACITY, {16'($urandom), cap_val});
      apb_access(1'b0, REG_BASE, 32'd0);
      apb_access(1'b0, REG_RBYTES, 32'd0);
      apb_access(1'b0, REG_CAPACITY, 32'd0);
      gaps_on = (phase % 3 != 2);
      repeat (35) send_random();
      settle();
    end

    if (mismatch_total == 0 && words_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
